[hw/rtl/tnc_pkg.sv]
package tnc_pkg;

   // Magnitudes are cut down to this many bits before normalizing
   localparam int RED_BITS = 31;
   localparam int SQ_W     = 2 * RED_BITS;
   localparam int SUM_W    = 64;
   localparam int REM_W    = SUM_W;
   // Quotient floor(2^30 * m^2 / S) never exceeds 2^30
   localparam int QUO_W    = 31;
   localparam int NUM_W    = QUO_W;
   localparam int ROOT_STEPS = (NUM_W + 1) / 2;
   // Integer root of a value up to 2^30 is at most 2^15
   localparam int ROOT_W   = 16;
   localparam int NORM_W   = 16;

   // Long division payload, one remainder and quotient per axis
   typedef struct packed {
      logic [2:0]                  neg;
      logic                        degen;
      logic [SUM_W-1:0]            sum_sq;
      logic [2:0][REM_W-1:0]       rem;
      logic [2:0][QUO_W-1:0]       quot;
   } div_type;

   // Square root payload, one remainder and partial root per axis
   typedef struct packed {
      logic [2:0]                  neg;
      logic                        degen;
      logic [2:0][NUM_W-1:0]       num;
      logic [2:0][NUM_W-1:0]       res;
   } root_type;

endpackage

[hw/rtl/tnc_if.sv]
interface tnc_req_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_x;
   logic signed [COORD_BITS-1:0] a_y;
   logic signed [COORD_BITS-1:0] a_z;
   logic signed [COORD_BITS-1:0] b_x;
   logic signed [COORD_BITS-1:0] b_y;
   logic signed [COORD_BITS-1:0] b_z;
   logic signed [COORD_BITS-1:0] c_x;
   logic signed [COORD_BITS-1:0] c_y;
   logic signed [COORD_BITS-1:0] c_z;

   modport source (
      output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
      input  ready
   );
   modport sink (
      input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
      output ready
   );
endinterface

interface tnc_rsp_if #(
   parameter int COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [15:0]           unit_nx;
   logic signed [15:0]           unit_ny;
   logic signed [15:0]           unit_nz;
   logic signed [COORD_BITS-1:0] mid_x;
   logic signed [COORD_BITS-1:0] mid_y;
   logic signed [COORD_BITS-1:0] mid_z;
   logic                         degenerate;

   modport source (
      output valid, unit_nx, unit_ny, unit_nz, mid_x, mid_y, mid_z, degenerate,
      input  ready
   );
   modport sink (
      input  valid, unit_nx, unit_ny, unit_nz, mid_x, mid_y, mid_z, degenerate,
      output ready
   );
endinterface

[hw/rtl/triangle_normal_centroid.sv]
// Channel   Port     Dir  Content
// request   req_if   in   vertices a, b, c (x, y, z each), signed Q8.8
// response  rsp_if   out  unit normal (Q1.14), centroid (Q8.8), degenerate flag
//
// One request per cycle unless the response stalls; the pipeline has 8 front stages (edges,
// cross product, reduction, squared length), 31 divider stages (one quotient bit
// each), 16 square root stages (one root bit each) and one output stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// A full stage holds while its successor is full and stalled; empty stages
// keep filling, so bubbles close up behind a stalled response.
module triangle_normal_centroid
   import tnc_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   tnc_req_if.sink    req_if,
   tnc_rsp_if.source  rsp_if
);

   localparam int MID_W = 3 * COORD_BITS;

   logic             front_valid, front_ready;
   div_type          front_data;
   logic [MID_W-1:0] front_mid;
   logic             div_valid, div_ready;
   div_type          div_data;
   logic [MID_W-1:0] div_mid;

   // Edges, cross product, centroid and squared length
   tnc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data),
      .out_mid   (front_mid)
   );

   // floor(2^30 * m^2 / S) per axis
   tnc_div #(
      .MID_W (MID_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .in_mid    (front_mid),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data),
      .out_mid   (div_mid)
   );

   // Integer root and rounding to the unit normal
   tnc_sqrt #(
      .COORD_BITS (COORD_BITS)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (div_valid),
      .in_ready (div_ready),
      .in_data  (div_data),
      .in_mid   (div_mid),
      .rsp_if   (rsp_if)
   );

endmodule

[hw/rtl/tnc_front.sv]
module tnc_front
   import tnc_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   tnc_req_if.sink                 req_if,
   output logic                    out_valid,
   input  logic                    out_ready,
   output div_type                 out_data,
   output logic [3*COORD_BITS-1:0] out_mid
);

   localparam int CB     = COORD_BITS;
   localparam int D_W    = CB + 1;
   localparam int S_W    = CB + 2;
   localparam int P_W    = 2 * CB + 2;
   localparam int MAG_W  = 2 * CB + 1;
   localparam int CM_W   = CB + 1;
   localparam int K      = CM_W + 2;
   localparam int CP_W   = CM_W + K;
   localparam logic [K-1:0] RECIP = K'((64'd1 << K) / 64'd3 + 64'd1);
   localparam int LEN_W  = $clog2(MAG_W + 1);
   localparam int EXT_W  = MAG_W + RED_BITS;
   localparam int STAGES = 8;

   // Stage handshake: a stage loads when empty or when its successor moves
   logic [STAGES:1]   v_ff;
   logic [STAGES:1]   v_in;
   wire  [STAGES+1:1] rdy;

   assign rdy[STAGES+1] = out_ready;
   for (genvar k = 1; k <= STAGES; k++) begin : g_rdy
      assign rdy[k] = ~v_ff[k] | rdy[k+1];
   end

   assign v_in         = {v_ff[STAGES-1:1], req_if.valid};
   assign req_if.ready = rdy[1];
   assign out_valid    = v_ff[STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   // Stage 1: edge vectors and vertex sums
   logic signed [CB-1:0]  pa[3], pb[3], pc[3];
   logic signed [D_W-1:0] u_in[3], w_in[3], u_ff[3], w_ff[3];
   logic signed [S_W-1:0] sum_in[3], sum_ff[3];

   assign pa[0] = req_if.a_x;
   assign pa[1] = req_if.a_y;
   assign pa[2] = req_if.a_z;
   assign pb[0] = req_if.b_x;
   assign pb[1] = req_if.b_y;
   assign pb[2] = req_if.b_z;
   assign pc[0] = req_if.c_x;
   assign pc[1] = req_if.c_y;
   assign pc[2] = req_if.c_z;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         u_in[j]   = D_W'(pb[j]) - D_W'(pa[j]);
         w_in[j]   = D_W'(pc[j]) - D_W'(pa[j]);
         sum_in[j] = S_W'(pa[j]) + S_W'(pb[j]) + S_W'(pc[j]);
      end
   end

   // Stage 2: six partial products, centroid sign and magnitude
   logic signed [P_W-1:0] p_in[6], p_ff[6];
   logic [2:0]            cneg2_in, cneg2_ff;
   logic [CM_W-1:0]       cmag_in[3], cmag_ff[3];

   always_comb begin
      p_in[0] = P_W'(u_ff[1]) * P_W'(w_ff[2]);
      p_in[1] = P_W'(u_ff[2]) * P_W'(w_ff[1]);
      p_in[2] = P_W'(u_ff[2]) * P_W'(w_ff[0]);
      p_in[3] = P_W'(u_ff[0]) * P_W'(w_ff[2]);
      p_in[4] = P_W'(u_ff[0]) * P_W'(w_ff[1]);
      p_in[5] = P_W'(u_ff[1]) * P_W'(w_ff[0]);
      for (int j = 0; j < 3; j++) begin
         cneg2_in[j] = sum_ff[j][S_W-1];
         cmag_in[j]  = cneg2_in[j] ? CM_W'(-sum_ff[j]) : CM_W'(sum_ff[j]);
      end
   end

   // Stage 3: cross product, centroid scaled by the reciprocal of three
   logic signed [P_W-1:0] n_in[3], n_ff[3];
   logic [2:0]            cneg3_ff;
   logic [CP_W-1:0]       cprod_in[3], cprod_ff[3];

   always_comb begin
      n_in[0] = p_ff[0] - p_ff[1];
      n_in[1] = p_ff[2] - p_ff[3];
      n_in[2] = p_ff[4] - p_ff[5];
      for (int j = 0; j < 3; j++) begin
         cprod_in[j] = CP_W'(cmag_ff[j]) * CP_W'(RECIP);
      end
   end

   // Stage 4: component magnitudes, zero test, signed centroid
   logic [2:0]            neg4_in, neg4_ff;
   logic [MAG_W-1:0]      mag4_in[3], mag4_ff[3];
   logic                  degen4_in, degen4_ff;
   logic [2:0][CB-1:0]    mid4_in, mid4_ff;
   logic [CM_W-1:0]       cq;

   always_comb begin
      cq = '0;
      for (int j = 0; j < 3; j++) begin
         neg4_in[j] = n_ff[j][P_W-1];
         mag4_in[j] = neg4_in[j] ? MAG_W'(-n_ff[j]) : MAG_W'(n_ff[j]);
         cq         = cprod_ff[j][CP_W-1:K];
         mid4_in[j] = cneg3_ff[j] ? CB'(-cq) : CB'(cq);
      end
      degen4_in = (n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0);
   end

   // Stage 5: bit length of the largest magnitude, right shift amount
   logic [2:0]         neg5_ff;
   logic [MAG_W-1:0]   mag5_ff[3];
   logic               degen5_ff;
   logic [2:0][CB-1:0] mid5_ff;
   logic [MAG_W-1:0]   or_mag;
   logic [LEN_W-1:0]   len;
   logic [LEN_W-1:0]   shift5_in, shift5_ff;

   always_comb begin
      or_mag = mag4_ff[0] | mag4_ff[1] | mag4_ff[2];
      len    = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (or_mag[i]) begin
            len = LEN_W'(i + 1);
         end
      end
      shift5_in = (len > LEN_W'(RED_BITS)) ? len - LEN_W'(RED_BITS) : '0;
   end

   // Stage 6: reduce magnitudes below 2^31
   logic [2:0]            neg6_ff;
   logic                  degen6_ff;
   logic [2:0][CB-1:0]    mid6_ff;
   logic [RED_BITS-1:0]   m6_in[3], m6_ff[3];
   logic [EXT_W-1:0]      ext;

   always_comb begin
      ext = '0;
      for (int j = 0; j < 3; j++) begin
         ext      = EXT_W'(mag5_ff[j]) >> shift5_ff;
         m6_in[j] = ext[RED_BITS-1:0];
      end
   end

   // Stage 7: squares
   logic [2:0]         neg7_ff;
   logic               degen7_ff;
   logic [2:0][CB-1:0] mid7_ff;
   logic [SQ_W-1:0]    sq7_in[3], sq7_ff[3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sq7_in[j] = SQ_W'(m6_ff[j]) * SQ_W'(m6_ff[j]);
      end
   end

   // Stage 8: squared length, division seeds
   div_type            out_in, out_ff;
   logic [2:0][CB-1:0] mid8_ff;

   always_comb begin
      out_in.neg    = neg7_ff;
      out_in.degen  = degen7_ff;
      out_in.sum_sq = SUM_W'(sq7_ff[0]) + SUM_W'(sq7_ff[1]) + SUM_W'(sq7_ff[2]);
      for (int j = 0; j < 3; j++) begin
         out_in.rem[j]  = REM_W'(sq7_ff[j]);
         out_in.quot[j] = '0;
      end
   end

   assign out_data = out_ff;
   assign out_mid  = mid8_ff;

   // Payload registers, loaded whenever their stage may advance
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         u_ff   <= u_in;
         w_ff   <= w_in;
         sum_ff <= sum_in;
      end
      if (rdy[2]) begin
         p_ff     <= p_in;
         cneg2_ff <= cneg2_in;
         cmag_ff  <= cmag_in;
      end
      if (rdy[3]) begin
         n_ff     <= n_in;
         cneg3_ff <= cneg2_ff;
         cprod_ff <= cprod_in;
      end
      if (rdy[4]) begin
         neg4_ff   <= neg4_in;
         mag4_ff   <= mag4_in;
         degen4_ff <= degen4_in;
         mid4_ff   <= mid4_in;
      end
      if (rdy[5]) begin
         neg5_ff   <= neg4_ff;
         mag5_ff   <= mag4_ff;
         degen5_ff <= degen4_ff;
         mid5_ff   <= mid4_ff;
         shift5_ff <= shift5_in;
      end
      if (rdy[6]) begin
         neg6_ff   <= neg5_ff;
         degen6_ff <= degen5_ff;
         mid6_ff   <= mid5_ff;
         m6_ff     <= m6_in;
      end
      if (rdy[7]) begin
         neg7_ff   <= neg6_ff;
         degen7_ff <= degen6_ff;
         mid7_ff   <= mid6_ff;
         sq7_ff    <= sq7_in;
      end
      if (rdy[8]) begin
         out_ff  <= out_in;
         mid8_ff <= mid7_ff;
      end
   end

endmodule

[hw/rtl/tnc_div.sv]
module tnc_div
   import tnc_pkg::*;
#(
   parameter int MID_W = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  div_type          in_data,
   input  logic [MID_W-1:0] in_mid,
   output logic             out_valid,
   input  logic             out_ready,
   output div_type          out_data,
   output logic [MID_W-1:0] out_mid
);

   // One quotient bit per stage
   localparam int STEPS = QUO_W;

   // Restoring step: double the remainder (not on the first bit), subtract S
   function automatic div_type div_step(div_type d, logic first);
      div_type          o;
      logic [REM_W:0]   r2;
      logic             ge;
      o = d;
      for (int j = 0; j < 3; j++) begin
         r2 = first ? {1'b0, d.rem[j]} : {d.rem[j], 1'b0};
         ge = r2 >= {1'b0, d.sum_sq};
         o.rem[j]  = ge ? REM_W'(r2 - {1'b0, d.sum_sq}) : REM_W'(r2);
         o.quot[j] = {d.quot[j][QUO_W-2:0], ge};
      end
      return o;
   endfunction

   div_type          st_in[STEPS], st_ff[STEPS];
   logic [MID_W-1:0] mid_in[STEPS], mid_ff[STEPS];
   logic [STEPS-1:0] v_in, v_ff;
   wire  [STEPS:0]   rdy;

   assign rdy[STEPS] = out_ready;
   for (genvar i = 0; i < STEPS; i++) begin : g_rdy
      assign rdy[i] = ~v_ff[i] | rdy[i+1];
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[STEPS-1];
   assign out_data  = st_ff[STEPS-1];
   assign out_mid   = mid_ff[STEPS-1];

   // Next value of every stage
   always_comb begin
      for (int i = 0; i < STEPS; i++) begin
         if (i == 0) begin
            st_in[i]  = div_step(in_data, 1'b1);
            mid_in[i] = in_mid;
            v_in[i]   = in_valid;
         end else begin
            st_in[i]  = div_step(st_ff[i-1], 1'b0);
            mid_in[i] = mid_ff[i-1];
            v_in[i]   = v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STEPS; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STEPS; i++) begin
         if (rdy[i]) begin
            st_ff[i]  <= st_in[i];
            mid_ff[i] <= mid_in[i];
         end
      end
   end

endmodule

[hw/rtl/tnc_sqrt.sv]
module tnc_sqrt
   import tnc_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  div_type                 in_data,
   input  logic [3*COORD_BITS-1:0] in_mid,
   tnc_rsp_if.source               rsp_if
);

   localparam int CB    = COORD_BITS;
   localparam int STEPS = ROOT_STEPS;

   // One root bit per stage
   function automatic root_type root_step(root_type d, logic [NUM_W-1:0] bit_val);
      root_type         o;
      logic [NUM_W:0]   t;
      logic             ge;
      o = d;
      for (int j = 0; j < 3; j++) begin
         t  = {1'b0, d.res[j]} + {1'b0, bit_val};
         ge = {1'b0, d.num[j]} >= t;
         o.num[j] = ge ? NUM_W'({1'b0, d.num[j]} - t) : d.num[j];
         o.res[j] = ge ? (d.res[j] >> 1) + bit_val : d.res[j] >> 1;
      end
      return o;
   endfunction

   root_type           seed;
   root_type           st_in[STEPS], st_ff[STEPS];
   logic [2:0][CB-1:0] mid_in[STEPS+1], mid_ff[STEPS+1];
   logic [STEPS:0]     v_in, v_ff;
   wire  [STEPS+1:0]   rdy;

   assign rdy[STEPS+1] = rsp_if.ready;
   for (genvar i = 0; i <= STEPS; i++) begin : g_rdy
      assign rdy[i] = ~v_ff[i] | rdy[i+1];
   end

   assign in_ready = rdy[0];

   // Root of the quotient starts from an empty partial root
   always_comb begin
      seed.neg   = in_data.neg;
      seed.degen = in_data.degen;
      for (int j = 0; j < 3; j++) begin
         seed.num[j] = in_data.quot[j];
         seed.res[j] = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < STEPS; i++) begin
         if (i == 0) begin
            st_in[i]  = root_step(seed, NUM_W'(1) << (2 * (STEPS - 1)));
            mid_in[i] = in_mid;
            v_in[i]   = in_valid;
         end else begin
            st_in[i]  = root_step(st_ff[i-1], NUM_W'(1) << (2 * (STEPS - 1 - i)));
            mid_in[i] = mid_ff[i-1];
            v_in[i]   = v_ff[i-1];
         end
      end
      mid_in[STEPS] = mid_ff[STEPS-1];
      v_in[STEPS]   = v_ff[STEPS-1];
   end

   // Output stage: round the root to the normal, apply sign, zero if degenerate
   root_type                  fin;
   logic [ROOT_W-1:0]         root;
   logic [ROOT_W:0]           root_inc;
   logic [NORM_W-1:0]         q;
   logic signed [NORM_W-1:0]  unit_in[3], unit_ff[3];
   logic                      degen_ff;

   always_comb begin
      fin      = st_ff[STEPS-1];
      root     = '0;
      root_inc = '0;
      q        = '0;
      for (int j = 0; j < 3; j++) begin
         root     = fin.res[j][ROOT_W-1:0];
         root_inc = {1'b0, root} + (ROOT_W + 1)'(1);
         q        = root_inc[ROOT_W:1];
         if (fin.degen) begin
            unit_in[j] = '0;
         end else begin
            unit_in[j] = fin.neg[j] ? -q : q;
         end
      end
   end

   assign rsp_if.valid      = v_ff[STEPS];
   assign rsp_if.unit_nx    = unit_ff[0];
   assign rsp_if.unit_ny    = unit_ff[1];
   assign rsp_if.unit_nz    = unit_ff[2];
   assign rsp_if.mid_x      = mid_ff[STEPS][0];
   assign rsp_if.mid_y      = mid_ff[STEPS][1];
   assign rsp_if.mid_z      = mid_ff[STEPS][2];
   assign rsp_if.degenerate = degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i <= STEPS; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STEPS; i++) begin
         if (rdy[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
      for (int i = 0; i <= STEPS; i++) begin
         if (rdy[i]) begin
            mid_ff[i] <= mid_in[i];
         end
      end
      if (rdy[STEPS]) begin
         unit_ff  <= unit_in;
         degen_ff <= fin.degen;
      end
   end

endmodule
